@@ rtl/core/circular_deque_list_engine_unit_defines.svh @@
// ============================================================================
// Assertion macros for the circular deque list engine
// Each check is written once, on one line, in the module it concerns.
// The macros compile to nothing when SYNTHESIS is defined.
// ============================================================================
`ifndef CIRCULAR_DEQUE_LIST_ENGINE_UNIT_DEFINES_SVH
`define CIRCULAR_DEQUE_LIST_ENGINE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define CDL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cdl check failed");
// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define CDL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cdl check failed");
`else
`define CDL_ASSERT_NOW(label, ante, cons)
`define CDL_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/core/cdl_pkg.sv @@
// ============================================================================
// cdl_pkg
// Shared widths, operation codes and status codes of the circular deque
// list engine.
// ============================================================================
package cdl_pkg;

    // Default sizes of the store.
    localparam int DEPTH_DEFAULT      = 16;
    localparam int DATA_WIDTH_DEFAULT = 32;

    // Fixed field widths of the request and response.
    localparam int OP_W     = 4;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 5;
    localparam int POS2_W   = 4;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 4'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 4'd1;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 4'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 4'd3;
    localparam logic [OP_W-1:0] OP_INSERT     = 4'd4;
    localparam logic [OP_W-1:0] OP_DELETE     = 4'd5;
    localparam logic [OP_W-1:0] OP_READ       = 4'd6;
    localparam logic [OP_W-1:0] OP_WRITE      = 4'd7;
    localparam logic [OP_W-1:0] OP_FIND       = 4'd8;
    localparam logic [OP_W-1:0] OP_COMPARE    = 4'd9;
    localparam logic [OP_W-1:0] OP_SWAP       = 4'd10;
    localparam logic [OP_W-1:0] OP_CLEAR      = 4'd11;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd3;

endpackage

@@ rtl/core/cdl_channels.sv @@
// ============================================================================
// cdl channels
// Request and response channels of the circular deque list engine, each
// with valid, ready and its payload.
// ============================================================================
interface cdl_req_if;
    logic                                valid;
    logic                                ready;
    logic [cdl_pkg::OP_W-1:0]            op;
    logic signed [cdl_pkg::DATA_W-1:0]   data;
    logic [cdl_pkg::POS_W-1:0]           position;
    logic [cdl_pkg::POS2_W-1:0]          other_position;

    modport source (output valid, output op, output data, output position,
                    output other_position, input ready);
    modport sink (input valid, input op, input data, input position,
                  input other_position, output ready);
endinterface

interface cdl_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [cdl_pkg::STATUS_W-1:0]        status;
    logic signed [cdl_pkg::DATA_W-1:0]   read_data;
    logic                                found;
    logic [cdl_pkg::OCC_W-1:0]           occupancy;

    modport source (output valid, output status, output read_data, output found,
                    output occupancy, input ready);
    modport sink (input valid, input status, input read_data, input found,
                  input occupancy, output ready);
endinterface

@@ rtl/core/cdl_ram.sv @@
// ============================================================================
// cdl_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module cdl_ram #(
    parameter int WIDTH = cdl_pkg::DATA_WIDTH_DEFAULT,
    parameter int DEPTH = cdl_pkg::DEPTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/circular_deque_list_engine_unit.sv @@
// ============================================================================
// circular_deque_list_engine_unit
// Ordered list of signed words kept in a circular RAM with a head slot and
// an entry count; one request in, one response out.
// ============================================================================
//
//  Channel  Dir  Handshake     Payload
//  req      in   valid/ready   op, data, position, other_position
//  rsp      out  valid/ready   status, read_data, found, occupancy
//
// Pushes, pops, write and clear finish in decode; read and compare add a read
// and a move step. Insert, delete and find take a read and a move step per
// entry moved or examined; insert then places the new entry. Each step goes
// through the one RAM read port, the one write port and the shared slot adder.
// Reset clears head and count at once; cells are not cleared.
// A request is taken only while idle; a waiting response does not block it.
//
`include "circular_deque_list_engine_unit_defines.svh"

module circular_deque_list_engine_unit #(
    parameter int DEPTH      = cdl_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = cdl_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    cdl_req_if.sink       req,
    cdl_rsp_if.source     rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > cdl_pkg::POS_W) ? CW : cdl_pkg::POS_W;
    localparam int VW = (DATA_WIDTH > cdl_pkg::DATA_W) ? DATA_WIDTH : cdl_pkg::DATA_W;
    localparam int SW = CW + 1;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_DECODE  = 9'b000000010,
        S_READ    = 9'b000000100,
        S_MOVE    = 9'b000001000,
        S_SWAP_RD = 9'b000010000,
        S_SWAP_WR = 9'b000100000,
        S_SWAP_WB = 9'b001000000,
        S_FINAL   = 9'b010000000,
        S_DONE    = 9'b100000000
    } cdl_state_t;

    // Control registers.
    cdl_state_t                    state_reg, state_next;
    logic [AW-1:0]                 head_reg, head_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [CW-1:0]                 idx_reg, idx_next;
    logic                          out_valid_reg, out_valid_next;

    // Payload registers.
    logic [cdl_pkg::OP_W-1:0]      op_reg;
    logic [DATA_WIDTH-1:0]         val_reg;
    logic [cdl_pkg::POS_W-1:0]     pos_reg;
    logic [cdl_pkg::POS2_W-1:0]    pos2_reg;
    logic [DATA_WIDTH-1:0]         tmp_reg, tmp_next;
    logic [cdl_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic [cdl_pkg::DATA_W-1:0]    rdata_reg, rdata_next;
    logic                          found_reg, found_next;
    logic [cdl_pkg::STATUS_W-1:0]  out_status_reg;
    logic [cdl_pkg::DATA_W-1:0]    out_rdata_reg;
    logic                          out_found_reg;
    logic [cdl_pkg::OCC_W-1:0]     out_occ_reg;

    // Datapath signals.
    logic                          in_fire;
    logic                          out_load;
    logic [VW-1:0]                 data_ext;
    logic [VW-1:0]                 rd_ext;
    logic [XW-1:0]                 cnt_x, pos_x, pos2_x;
    logic [CW-1:0]                 pos_k, pos2_k;
    logic                          is_full, is_empty;
    logic                          pos_lt_cnt, pos_gt_cnt, pos2_lt_cnt;
    logic [AW-1:0]                 head_dec;
    logic [CW-1:0]                 idx_dn, idx_up, idx_up2;
    logic [CW-1:0]                 slot_k;
    logic [SW-1:0]                 slot_sum;
    logic [AW-1:0]                 slot;
    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic [DATA_WIDTH-1:0]         mem_wdata;
    logic [DATA_WIDTH-1:0]         mem_rdata;

    // Conditions watched by the checks.
    logic                          full_push;
    logic                          rsp_rejected;
    logic                          quiet_state;

    // Handshakes.
    assign req.ready = (state_reg == S_IDLE);
    assign in_fire   = req.valid && req.ready;

    // Incoming data, zero-extended or cut to the stored width.
    assign data_ext = VW'($unsigned(req.data));

    // Read data sign-extended from the stored width.
    assign rd_ext = VW'($signed(mem_rdata));

    // Position checks against the count.
    assign cnt_x       = XW'(count_reg);
    assign pos_x       = XW'(pos_reg);
    assign pos2_x      = XW'(pos2_reg);
    assign pos_k       = CW'(pos_x);
    assign pos2_k      = CW'(pos2_x);
    assign is_full     = (count_reg == CW'(DEPTH));
    assign is_empty    = (count_reg == '0);
    assign pos_lt_cnt  = (pos_x < cnt_x);
    assign pos_gt_cnt  = (pos_x > cnt_x);
    assign pos2_lt_cnt = (pos2_x < cnt_x);

    // Loop index neighbors and the slot before the head.
    assign idx_dn   = idx_reg - CW'(1);
    assign idx_up   = idx_reg + CW'(1);
    assign idx_up2  = idx_reg + CW'(2);
    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : (head_reg - AW'(1));

    // Shared slot unit: logical position to physical slot.
    assign slot_sum = SW'(head_reg) + SW'(slot_k);
    assign slot     = (slot_sum >= SW'(DEPTH)) ? AW'(slot_sum - SW'(DEPTH)) : AW'(slot_sum);

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        tmp_next    = tmp_reg;
        status_next = status_reg;
        rdata_next  = rdata_reg;
        found_next  = found_reg;
        slot_k      = idx_reg;
        mem_we      = 1'b0;
        mem_waddr   = slot;
        mem_wdata   = val_reg;
        out_load    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    status_next = cdl_pkg::ST_OK;
                    rdata_next  = '0;
                    found_next  = 1'b0;
                    state_next  = S_DECODE;
                end
            end

            S_DECODE:
            begin
                state_next = S_DONE;
                case (op_reg)
                    cdl_pkg::OP_PUSH_BACK:
                    begin
                        slot_k = count_reg;
                        if (is_full)
                        begin
                            status_next = cdl_pkg::ST_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    cdl_pkg::OP_PUSH_FRONT:
                    begin
                        if (is_full)
                        begin
                            status_next = cdl_pkg::ST_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = head_dec;
                            head_next  = head_dec;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    cdl_pkg::OP_POP_BACK:
                    begin
                        if (is_empty)
                        begin
                            status_next = cdl_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                        end
                    end
                    cdl_pkg::OP_POP_FRONT:
                    begin
                        slot_k = CW'(1);
                        if (is_empty)
                        begin
                            status_next = cdl_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            head_next  = slot;
                            count_next = count_reg - CW'(1);
                        end
                    end
                    cdl_pkg::OP_INSERT:
                    begin
                        if (pos_gt_cnt)
                        begin
                            status_next = cdl_pkg::ST_BAD_POS;
                        end
                        else if (is_full)
                        begin
                            status_next = cdl_pkg::ST_FULL;
                        end
                        else
                        begin
                            idx_next   = count_reg;
                            state_next = pos_lt_cnt ? S_READ : S_FINAL;
                        end
                    end
                    cdl_pkg::OP_DELETE:
                    begin
                        if (is_empty)
                        begin
                            status_next = cdl_pkg::ST_EMPTY;
                        end
                        else if (!pos_lt_cnt)
                        begin
                            status_next = cdl_pkg::ST_BAD_POS;
                        end
                        else if ((pos_x + XW'(1)) < cnt_x)
                        begin
                            idx_next   = pos_k;
                            state_next = S_READ;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                        end
                    end
                    cdl_pkg::OP_READ, cdl_pkg::OP_COMPARE:
                    begin
                        if (!pos_lt_cnt)
                        begin
                            status_next = cdl_pkg::ST_BAD_POS;
                        end
                        else
                        begin
                            idx_next   = pos_k;
                            state_next = S_READ;
                        end
                    end
                    cdl_pkg::OP_SWAP:
                    begin
                        if (!pos_lt_cnt || !pos2_lt_cnt)
                        begin
                            status_next = cdl_pkg::ST_BAD_POS;
                        end
                        else
                        begin
                            idx_next   = pos_k;
                            state_next = S_READ;
                        end
                    end
                    cdl_pkg::OP_WRITE:
                    begin
                        slot_k = pos_k;
                        if (!pos_lt_cnt)
                        begin
                            status_next = cdl_pkg::ST_BAD_POS;
                        end
                        else
                        begin
                            mem_we = 1'b1;
                        end
                    end
                    cdl_pkg::OP_FIND:
                    begin
                        if (!is_empty)
                        begin
                            idx_next   = '0;
                            state_next = S_READ;
                        end
                    end
                    cdl_pkg::OP_CLEAR:
                    begin
                        count_next = '0;
                        head_next  = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            // Present the read address; insert copies from below, delete from above.
            S_READ:
            begin
                if (op_reg == cdl_pkg::OP_INSERT)
                begin
                    slot_k = idx_dn;
                end
                else if (op_reg == cdl_pkg::OP_DELETE)
                begin
                    slot_k = idx_up;
                end
                else
                begin
                    slot_k = idx_reg;
                end
                state_next = S_MOVE;
            end

            // Read data is back: move it, test it or capture it.
            S_MOVE:
            begin
                state_next = S_DONE;
                case (op_reg)
                    cdl_pkg::OP_INSERT:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = mem_rdata;
                        idx_next  = idx_dn;
                        state_next = (idx_dn > pos_k) ? S_READ : S_FINAL;
                    end
                    cdl_pkg::OP_DELETE:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = mem_rdata;
                        idx_next  = idx_up;
                        if (idx_up2 < count_reg)
                        begin
                            state_next = S_READ;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                        end
                    end
                    cdl_pkg::OP_FIND:
                    begin
                        if (mem_rdata == val_reg)
                        begin
                            found_next = 1'b1;
                        end
                        else if (idx_up < count_reg)
                        begin
                            idx_next   = idx_up;
                            state_next = S_READ;
                        end
                    end
                    cdl_pkg::OP_READ:
                    begin
                        rdata_next = rd_ext[cdl_pkg::DATA_W-1:0];
                    end
                    cdl_pkg::OP_COMPARE:
                    begin
                        found_next = (mem_rdata == val_reg);
                    end
                    cdl_pkg::OP_SWAP:
                    begin
                        tmp_next   = mem_rdata;
                        state_next = S_SWAP_RD;
                    end
                    default:
                    begin
                    end
                endcase
            end

            // Swap: read the second entry, then write both back crosswise.
            S_SWAP_RD:
            begin
                slot_k     = pos2_k;
                state_next = S_SWAP_WR;
            end

            S_SWAP_WR:
            begin
                slot_k     = pos_k;
                mem_we     = 1'b1;
                mem_wdata  = mem_rdata;
                state_next = S_SWAP_WB;
            end

            S_SWAP_WB:
            begin
                slot_k     = pos2_k;
                mem_we     = 1'b1;
                mem_wdata  = tmp_reg;
                state_next = S_DONE;
            end

            // Insert: the gap is open, place the new entry.
            S_FINAL:
            begin
                slot_k     = pos_k;
                mem_we     = 1'b1;
                count_next = count_reg + CW'(1);
                state_next = S_DONE;
            end

            // Hand the response to the output register once it is free.
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register valid.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: request fields, working result and output register.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg   <= req.op;
            val_reg  <= data_ext[DATA_WIDTH-1:0];
            pos_reg  <= req.position;
            pos2_reg <= req.other_position;
        end
        tmp_reg    <= tmp_next;
        status_reg <= status_next;
        rdata_reg  <= rdata_next;
        found_reg  <= found_next;
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_rdata_reg  <= rdata_reg;
            out_found_reg  <= found_reg;
            out_occ_reg    <= cdl_pkg::OCC_W'(count_reg);
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.read_data = out_rdata_reg;
    assign rsp.found     = out_found_reg;
    assign rsp.occupancy = out_occ_reg;

    // Cell store.
    cdl_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_cells (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (slot),
        .rdata (mem_rdata)
    );

    // Push decoded on a full list, rejected response on the output, and
    // the states in which the RAM is never written.
    assign full_push    = (state_reg == S_DECODE) && is_full &&
                          ((op_reg == cdl_pkg::OP_PUSH_BACK) ||
                           (op_reg == cdl_pkg::OP_PUSH_FRONT));
    assign rsp_rejected = rsp.valid && (rsp.status != cdl_pkg::ST_OK);
    assign quiet_state  = state_reg inside {S_IDLE, S_DONE, S_READ};

    // Checks on the sequencer and the result.
    `CDL_ASSERT_NOW(a_count_bound, 1'b1, (count_reg <= CW'(DEPTH)) && (int'(head_reg) < DEPTH))
    `CDL_ASSERT_NEXT(a_one_at_a_time, in_fire, !req.ready)
    `CDL_ASSERT_NEXT(a_full_push_rejected, full_push, status_reg == cdl_pkg::ST_FULL)
    `CDL_ASSERT_NEXT(a_full_push_keeps_list, full_push, $stable(count_reg) && $stable(head_reg))
    `CDL_ASSERT_NOW(a_reject_clean, rsp_rejected, (rsp.read_data == '0) && !rsp.found)
    `CDL_ASSERT_NOW(a_no_write_when_idle, quiet_state, !mem_we)

endmodule
